@@ design/bounded_key_value_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the key/value table
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define BOUNDED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// check cons in the same cycle as ante
`define BKV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bkv assertion failed");

// check cons in the cycle after ante
`define BKV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bkv assertion failed");

`endif

@@ design/bkv_pkg.sv @@
// ----------------------------------------------------------------------------
// Key/value table package
// Sizes, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package bkv_pkg;

  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] data_word;
  } cell_ctl_t;

endpackage

@@ design/bkv_if.sv @@
// ----------------------------------------------------------------------------
// Key/value table channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
interface bkv_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [bkv_pkg::KEY_W-1:0]  key;
  logic [bkv_pkg::VAL_W-1:0]  data_word;

  modport source (output valid, output operation, output key, output data_word,
                  input ready);
  modport sink   (input valid, input operation, input key, input data_word,
                  output ready);
endinterface

interface bkv_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [bkv_pkg::VAL_W-1:0]  read_value;
  logic [1:0]                 status;
  logic [4:0]                 entry_count;

  modport source (output valid, output found, output read_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input read_value, input status,
                  input entry_count, output ready);
endinterface

@@ design/bkv_cell.sv @@
// ----------------------------------------------------------------------------
// Key/value table cell
// Holds one pair, matches the request key and passes match and value down the row.
// ----------------------------------------------------------------------------
module bkv_cell (
  input  logic                       clk,
  input  bkv_pkg::cell_ctl_t         ctl,
  input  logic                       occ,
  input  logic                       ins_slot,
  input  logic [bkv_pkg::KEY_W-1:0]  nb_key,
  input  logic [bkv_pkg::VAL_W-1:0]  nb_value,
  input  logic                       before_in,
  input  logic [bkv_pkg::VAL_W-1:0]  sel_in,
  output logic [bkv_pkg::KEY_W-1:0]  key_q,
  output logic [bkv_pkg::VAL_W-1:0]  value_q,
  output logic                       before_out,
  output logic [bkv_pkg::VAL_W-1:0]  sel_out
);

  logic [bkv_pkg::KEY_W-1:0] key_r;
  logic [bkv_pkg::VAL_W-1:0] value_r;
  logic                      hit;
  logic                      first;

  assign hit        = occ && (key_r == ctl.key);
  assign first      = hit && !before_in;
  assign before_out = before_in || hit;
  assign sel_out    = sel_in | (first ? value_r : '0);
  assign key_q      = key_r;
  assign value_q    = value_r;

  always_ff @(posedge clk) begin
    if (ctl.rem_en && before_out) begin
      key_r   <= nb_key;
      value_r <= nb_value;
    end else if (ctl.ins_en && ins_slot) begin
      key_r   <= ctl.key;
      value_r <= ctl.data_word;
    end
  end

endmodule

@@ design/bounded_key_value_table_core.sv @@
// Response: registered when its request is accepted and valid in the cycle after.
// Throughput: one request per cycle, stalled only while a response waits untaken;
//   the row of cells matches in parallel and shifts on removal in the same cycle.
// Reset: rst_n synchronous, active low, empties the table and the output register;
//   stored pairs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Key/value table core
// Bounded table of key/value pairs kept packed in insertion order.
// ----------------------------------------------------------------------------
`include "bounded_key_value_table_core_defines.svh"

module bounded_key_value_table_core (
  input  logic        clk,
  input  logic        rst_n,
  bkv_req_if.sink     in_req,
  bkv_rsp_if.source   out_rsp
);

  localparam int E  = bkv_pkg::ENTRIES;
  localparam int CW = bkv_pkg::CNT_W;

  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       out_valid_r;
  logic                       out_found_r;
  logic [bkv_pkg::VAL_W-1:0]  out_value_r;
  logic [1:0]                 out_status_r;
  logic [CW-1:0]              out_cnt_r;
  logic [CW+4:0]              cnt_ext;

  logic                       accept;
  logic                       found;
  logic                       full;
  logic [1:0]                 status_nxt;
  logic [bkv_pkg::VAL_W-1:0]  value_nxt;
  bkv_pkg::cell_ctl_t         ctl;

  logic                       seen   [E+1];
  logic [bkv_pkg::VAL_W-1:0]  sel    [E+1];
  logic [bkv_pkg::KEY_W-1:0]  key_q  [E];
  logic [bkv_pkg::VAL_W-1:0]  value_q[E];

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign full         = (cnt_r == CW'(E));
  assign seen[0]      = 1'b0;
  assign sel[0]       = '0;
  assign found        = seen[E];

  always_comb begin
    status_nxt = bkv_pkg::ST_DONE;
    value_nxt  = '0;
    cnt_nxt    = cnt_r;
    case (in_req.operation)
      bkv_pkg::OP_INSERT: begin
        if (found) begin
          status_nxt = bkv_pkg::ST_PRESENT;
        end else if (full) begin
          status_nxt = bkv_pkg::ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      bkv_pkg::OP_LOOKUP: begin
        if (found) begin
          value_nxt = sel[E];
        end else begin
          status_nxt = bkv_pkg::ST_ABSENT;
        end
      end
      bkv_pkg::OP_REMOVE: begin
        if (found) begin
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          status_nxt = bkv_pkg::ST_ABSENT;
        end
      end
      default: begin
        status_nxt = bkv_pkg::ST_DONE;
      end
    endcase
  end

  always_comb begin
    ctl.key       = in_req.key;
    ctl.data_word = in_req.data_word;
    ctl.ins_en    = accept && (in_req.operation == bkv_pkg::OP_INSERT) && !found && !full;
    ctl.rem_en    = accept && (in_req.operation == bkv_pkg::OP_REMOVE) && found;
  end

  for (genvar i = 0; i < E; i++) begin : g_cell
    logic [bkv_pkg::KEY_W-1:0] nb_key;
    logic [bkv_pkg::VAL_W-1:0] nb_value;
    if (i < E - 1) begin : g_mid
      assign nb_key   = key_q[i+1];
      assign nb_value = value_q[i+1];
    end else begin : g_last
      assign nb_key   = key_q[i];
      assign nb_value = value_q[i];
    end
    bkv_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (CW'(i) < cnt_r),
      .ins_slot   (CW'(i) == cnt_r),
      .nb_key     (nb_key),
      .nb_value   (nb_value),
      .before_in  (seen[i]),
      .sel_in     (sel[i]),
      .key_q      (key_q[i]),
      .value_q    (value_q[i]),
      .before_out (seen[i+1]),
      .sel_out    (sel[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_found_r  <= found;
      out_value_r  <= value_nxt;
      out_status_r <= status_nxt;
      out_cnt_r    <= cnt_nxt;
    end
  end

  assign cnt_ext             = {5'd0, out_cnt_r};
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.found       = out_found_r;
  assign out_rsp.read_value  = out_value_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.entry_count = cnt_ext[4:0];

  `BKV_ASSERT_NEXT(a_insert_grows, ctl.ins_en, cnt_r == $past(cnt_r) + CW'(1))
  `BKV_ASSERT_NEXT(a_remove_shrinks, ctl.rem_en, cnt_r == $past(cnt_r) - CW'(1))
  `BKV_ASSERT_NOW(a_found_not_absent, out_valid_r && out_found_r, out_status_r != bkv_pkg::ST_ABSENT)
  `BKV_ASSERT_NOW(a_count_bounded, out_valid_r, (out_cnt_r <= CW'(E)) && (cnt_r <= CW'(E)))

endmodule
